/* rtl/grrd_pkg.sv */
package grrd_pkg;

  localparam int MAX_CONSUMERS_DEF = 16;
  localparam int NUM_GROUPS_DEF    = 3;

  localparam int HANDLE_W = 16;
  localparam int GROUP_W  = 2;

  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_DISPATCHED = 2'd0,
    ST_REGISTERED = 2'd1,
    ST_REFUSED    = 2'd2
  } status_t;

  typedef struct packed {
    logic                mode;
    logic [HANDLE_W-1:0] consumer_handle;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [GROUP_W-1:0]  group_id;
    logic [HANDLE_W-1:0] chosen_handle;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [GROUP_W-1:0]  tag;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

/* rtl/grrd_ram.sv */
module grrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/grouped_round_robin_dispatch.sv */
// Channel   Handshake                 Payload
// item      start in, busy out        in_item_t  (mode, consumer_handle)
// result    result_valid out, strobe  out_item_t (status, group_id, chosen_handle, last)
//
// A register transaction does not make the block busy; its result shows in the next cycle.
// A dispatch transaction walks the slot table through the single read port of
// the table RAM, one slot per cycle, for each group in turn, with a setup step
// before each group's scan.
// Reset clears the consumer count, group pointer and last picks; the table itself is not cleared.
// The receiver cannot stall: each result is held for exactly one cycle.
module grouped_round_robin_dispatch
  import grrd_pkg::*;
#(
  parameter int MAX_CONSUMERS = MAX_CONSUMERS_DEF,
  parameter int NUM_GROUPS    = NUM_GROUPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  item,
  output logic      busy,
  output logic      result_valid,
  output out_item_t result
);

  localparam int AW  = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
  localparam int CW  = $clog2(MAX_CONSUMERS + 1);
  localparam int GIW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam logic [CW-1:0]      FULL_COUNT = CW'(MAX_CONSUMERS);
  localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(NUM_GROUPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [GROUP_W-1:0] next_group;
  logic [GROUP_W-1:0] cur_group;
  logic [AW-1:0]      pos;
  logic [CW-1:0]      issued;
  logic               rd_vld;
  logic [AW-1:0]      rd_slot;
  logic [AW-1:0]      lp_idx [NUM_GROUPS];
  logic               lp_vld [NUM_GROUPS];
  logic               pend_vld;
  out_item_t          pend;

  logic               accept;
  logic               tbl_we;
  entry_t             tbl_wdata;
  entry_t             tbl_rdata;
  logic [AW-1:0]      last_pos;
  logic [AW-1:0]      start_pos;
  logic [AW-1:0]      pos_dec;
  logic [GIW-1:0]     gi;
  logic               hit;
  logic               scan_end;
  logic [GROUP_W-1:0] group_adv;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign tbl_we    = accept && (item.mode == MODE_REGISTER) && (count != FULL_COUNT);
  assign tbl_wdata = '{tag: next_group, handle: item.consumer_handle};
  assign last_pos  = AW'(count - CW'(1));
  assign gi        = cur_group[GIW-1:0];
  assign pos_dec   = (pos == '0) ? last_pos : AW'(pos - AW'(1));
  assign hit       = rd_vld && (tbl_rdata.tag == cur_group);
  assign scan_end  = (issued == count);
  assign group_adv = (next_group == LAST_GROUP) ? '0 : GROUP_W'(next_group + GROUP_W'(1));

  always_comb begin
    if (lp_vld[gi]) begin
      start_pos = (lp_idx[gi] == '0) ? last_pos : AW'(lp_idx[gi] - AW'(1));
    end else begin
      start_pos = last_pos;
    end
  end

  grrd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_CONSUMERS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count[AW-1:0]),
    .wdata (tbl_wdata),
    .raddr (pos),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      next_group   <= '0;
      cur_group    <= '0;
      rd_vld       <= 1'b0;
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        lp_idx[i] <= '0;
        lp_vld[i] <= 1'b0;
      end
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.mode == MODE_REGISTER) begin
              result_valid         <= 1'b1;
              result.group_id      <= next_group;
              result.chosen_handle <= item.consumer_handle;
              result.last          <= 1'b1;
              if (count == FULL_COUNT) begin
                result.status <= ST_REFUSED;
              end else begin
                result.status <= ST_REGISTERED;
                count         <= CW'(count + CW'(1));
                next_group    <= group_adv;
              end
            end else if (count != '0) begin
              cur_group <= '0;
              pend_vld  <= 1'b0;
              state     <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          pos    <= start_pos;
          issued <= '0;
          rd_vld <= 1'b0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (!scan_end) begin
            pos     <= pos_dec;
            issued  <= CW'(issued + CW'(1));
            rd_vld  <= 1'b1;
            rd_slot <= pos;
          end else begin
            rd_vld <= 1'b0;
          end
          if (hit) begin
            lp_idx[gi] <= rd_slot;
            lp_vld[gi] <= 1'b1;
            if (pend_vld) begin
              result_valid <= 1'b1;
              result       <= pend;
            end
            pend     <= '{status: ST_DISPATCHED, group_id: cur_group,
                          chosen_handle: tbl_rdata.handle, last: 1'b0};
            pend_vld <= 1'b1;
          end
          if (hit || scan_end) begin
            if (cur_group == LAST_GROUP) begin
              state <= S_FLUSH;
            end else begin
              cur_group <= GROUP_W'(cur_group + GROUP_W'(1));
              state     <= S_SETUP;
            end
          end
        end
        S_FLUSH: begin
          if (pend_vld) begin
            result_valid <= 1'b1;
            result       <= '{status: pend.status, group_id: pend.group_id,
                              chosen_handle: pend.chosen_handle, last: 1'b1};
          end
          pend_vld <= 1'b0;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* test/tb_top.sv */
module tb_top;
  import grrd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 64;
  localparam int RANDOM_ITEMS = 350;

  class dispatch_scoreboard;
    logic [HANDLE_W-1:0] handles [MAX_CONSUMERS_DEF];
    logic [GROUP_W-1:0]  tags [MAX_CONSUMERS_DEF];
    int                  count;
    int                  next_grp;
    int                  pick_idx [NUM_GROUPS_DEF];
    bit                  pick_ok [NUM_GROUPS_DEF];
    out_item_t           expected_results [$];
    int                  error_count;

    function new();
      count = 0;
      next_grp = 0;
      error_count = 0;
      for (int g = 0; g < NUM_GROUPS_DEF; g++) begin
        pick_idx[g] = 0;
        pick_ok[g] = 1'b0;
      end
    endfunction

    // round-robin search, newest to oldest, starting just past the last pick
    function int find_member(int g);
      int lp;
      int pos;
      if (count == 0) return -1;
      if (pick_ok[g]) begin
        lp = pick_idx[g] % count;
        pos = (lp == 0) ? count - 1 : lp - 1;
      end else begin
        pos = count - 1;
      end
      for (int s = 0; s < count; s++) begin
        if (tags[pos] == g) return pos;
        pos = (pos == 0) ? count - 1 : pos - 1;
      end
      return -1;
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int        slot [NUM_GROUPS_DEF];
      int        final_grp;
      r.last = 1'b1;
      if (it.mode == MODE_REGISTER) begin
        r.group_id = next_grp[GROUP_W-1:0];
        r.chosen_handle = it.consumer_handle;
        if (count >= MAX_CONSUMERS_DEF) begin
          r.status = ST_REFUSED;
        end else begin
          handles[count] = it.consumer_handle;
          tags[count] = next_grp[GROUP_W-1:0];
          count++;
          next_grp = (next_grp + 1) % NUM_GROUPS_DEF;
          r.status = ST_REGISTERED;
        end
        expected_results.push_back(r);
      end else begin
        final_grp = -1;
        for (int g = 0; g < NUM_GROUPS_DEF; g++) begin
          slot[g] = find_member(g);
          if (slot[g] >= 0) begin
            pick_idx[g] = slot[g];
            pick_ok[g] = 1'b1;
            final_grp = g;
          end
        end
        for (int g = 0; g < NUM_GROUPS_DEF; g++) begin
          if (slot[g] >= 0) begin
            r.status = ST_DISPATCHED;
            r.group_id = g[GROUP_W-1:0];
            r.chosen_handle = handles[slot[g]];
            r.last = (g == final_grp);
            expected_results.push_back(r);
          end
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d group %0d handle %h last %0b",
               got.status, got.group_id, got.chosen_handle, got.last);
        error_count++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        error_count++;
      end
      if (got.group_id !== exp.group_id) begin
        $error("group_id: expected %0d, got %0d", exp.group_id, got.group_id);
        error_count++;
      end
      if (got.chosen_handle !== exp.chosen_handle) begin
        $error("chosen_handle: expected %h, got %h", exp.chosen_handle, got.chosen_handle);
        error_count++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        error_count++;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  item;
  logic      busy;
  logic      result_valid;
  out_item_t result;

  dispatch_scoreboard sb;
  int                 cycles;
  int                 burst_left;

  grouped_round_robin_dispatch u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(item);
      if (result_valid) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hold start until the transaction is taken, then either continue the burst or idle
  task automatic issue(input logic mode_bit, input logic [HANDLE_W-1:0] h);
    in_item_t it;
    it.mode = mode_bit;
    it.consumer_handle = h;
    item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    burst_left = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    issue(MODE_DISPATCH, 16'h0000);
    issue(MODE_DISPATCH, 16'hFFFF);
    issue(MODE_REGISTER, 16'h0000);
    issue(MODE_DISPATCH, 16'h1234);
    issue(MODE_DISPATCH, 16'h0000);
    issue(MODE_REGISTER, 16'hFFFF);
    issue(MODE_DISPATCH, 16'h0000);
    issue(MODE_REGISTER, 16'hA5A5);
    issue(MODE_DISPATCH, 16'hFFFF);
    issue(MODE_DISPATCH, 16'h0000);
    issue(MODE_DISPATCH, 16'h0000);
    issue(MODE_REGISTER, 16'h5A5A);
    issue(MODE_REGISTER, 16'h8001);
    issue(MODE_DISPATCH, 16'h0000);
    issue(MODE_DISPATCH, 16'h0000);
    issue(MODE_DISPATCH, 16'h0000);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue(($urandom_range(0, 3) == 0) ? MODE_REGISTER : MODE_DISPATCH,
            16'($urandom));
      if (i == 120 || i == 260) drain();
    end

    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/grrd_pkg.sv
rtl/grrd_ram.sv
rtl/grouped_round_robin_dispatch.sv
test/tb_top.sv
